@@ design/jses_pkg.sv @@
`timescale 1ns / 1ps

package jses_pkg;

  localparam int unsigned MaxBytes = 7;
  localparam int unsigned CntW     = 3;
  localparam int unsigned EncBytes = 6;

  localparam logic [7:0] REPL_RESET  = 8'h3F;
  localparam logic [7:0] CH_CTRL_LIM = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_FF       = 8'h0C;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LO_B     = 8'h62;
  localparam logic [7:0] CH_LO_F     = 8'h66;
  localparam logic [7:0] CH_LO_N     = 8'h6E;
  localparam logic [7:0] CH_LO_R     = 8'h72;
  localparam logic [7:0] CH_LO_T     = 8'h74;
  localparam logic [7:0] CH_LO_U     = 8'h75;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] UTF_CONT    = 8'h80;
  localparam logic [7:0] UTF_LEAD2   = 8'hC0;
  localparam logic [7:0] UTF_LEAD3   = 8'hE0;
  localparam logic [7:0] UTF_LEAD4   = 8'hF0;

  localparam logic [5:0]  SURR_HI_TAG = 6'b110110;
  localparam logic [5:0]  SURR_LO_TAG = 6'b110111;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       string_done;
  } out_t;

  typedef logic [MaxBytes-1:0][7:0] run_bytes_t;

  // encoder result towards the run register and the surrogate holding register
  typedef struct packed {
    run_bytes_t      bytes;
    logic [CntW-1:0] cnt;
    logic            pend_valid;
    logic [9:0]      pend_high;
  } enc_res_t;

  function automatic logic [7:0] hex_lower(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'h0, v};
    end else begin
      r = 8'h61 + {4'h0, v} - 8'd10;
    end
    return r;
  endfunction

endpackage

@@ design/jses_encode.sv @@
`timescale 1ns / 1ps

module jses_encode (
  input  jses_pkg::in_t      unit_i,
  input  logic               pend_valid_i,
  input  logic [9:0]         pend_high_i,
  input  logic [7:0]         repl_i,
  output jses_pkg::enc_res_t res_o
);

  logic [15:0] u;
  logic        is_hi;
  logic        is_lo;
  logic        pair;
  logic        prefix;
  logic [20:0] cp;
  logic [jses_pkg::EncBytes-1:0][7:0] e;
  logic [jses_pkg::CntW-1:0] ecnt;

  assign u     = unit_i.code_unit;
  assign is_hi = (u[15:10] == jses_pkg::SURR_HI_TAG);
  assign is_lo = (u[15:10] == jses_pkg::SURR_LO_TAG);
  assign pair  = pend_valid_i && is_lo;
  // a waiting high surrogate that finds no partner is replaced first
  assign prefix = pend_valid_i && !is_lo;
  assign cp    = jses_pkg::SUPP_BASE + {1'b0, pend_high_i, u[9:0]};

  // bytes of the unit on its own
  always_comb begin
    e    = '0;
    ecnt = '0;
    if (u < 16'h0080) begin
      if ((u[7:0] < jses_pkg::CH_CTRL_LIM) || (u[7:0] == jses_pkg::CH_QUOTE) ||
          (u[7:0] == jses_pkg::CH_BSLASH)) begin
        e[0] = jses_pkg::CH_BSLASH;
        ecnt = 3'd2;
        case (u[7:0])
          jses_pkg::CH_QUOTE:  e[1] = jses_pkg::CH_QUOTE;
          jses_pkg::CH_BSLASH: e[1] = jses_pkg::CH_BSLASH;
          jses_pkg::CH_BS:     e[1] = jses_pkg::CH_LO_B;
          jses_pkg::CH_FF:     e[1] = jses_pkg::CH_LO_F;
          jses_pkg::CH_NL:     e[1] = jses_pkg::CH_LO_N;
          jses_pkg::CH_CR:     e[1] = jses_pkg::CH_LO_R;
          jses_pkg::CH_TAB:    e[1] = jses_pkg::CH_LO_T;
          default: begin
            e[1] = jses_pkg::CH_LO_U;
            e[2] = jses_pkg::CH_ZERO;
            e[3] = jses_pkg::CH_ZERO;
            e[4] = jses_pkg::hex_lower(u[7:4]);
            e[5] = jses_pkg::hex_lower(u[3:0]);
            ecnt = 3'd6;
          end
        endcase
      end else begin
        e[0] = u[7:0];
        ecnt = 3'd1;
      end
    end else if (u < 16'h0800) begin
      e[0] = jses_pkg::UTF_LEAD2 | {3'b000, u[10:6]};
      e[1] = jses_pkg::UTF_CONT | {2'b00, u[5:0]};
      ecnt = 3'd2;
    end else if (is_hi) begin
      // held for its partner unless the string ends here
      if (unit_i.end_of_string) begin
        e[0] = repl_i;
        ecnt = 3'd1;
      end
    end else if (is_lo) begin
      e[0] = repl_i;
      ecnt = 3'd1;
    end else begin
      e[0] = jses_pkg::UTF_LEAD3 | {4'h0, u[15:12]};
      e[1] = jses_pkg::UTF_CONT | {2'b00, u[11:6]};
      e[2] = jses_pkg::UTF_CONT | {2'b00, u[5:0]};
      ecnt = 3'd3;
    end
  end

  always_comb begin
    res_o.pend_high = u[9:0];
    if (pair) begin
      res_o.bytes    = '0;
      res_o.bytes[0] = jses_pkg::UTF_LEAD4 | {5'b00000, cp[20:18]};
      res_o.bytes[1] = jses_pkg::UTF_CONT | {2'b00, cp[17:12]};
      res_o.bytes[2] = jses_pkg::UTF_CONT | {2'b00, cp[11:6]};
      res_o.bytes[3] = jses_pkg::UTF_CONT | {2'b00, cp[5:0]};
      res_o.cnt        = 3'd4;
      res_o.pend_valid = 1'b0;
    end else begin
      if (prefix) begin
        res_o.bytes = {e, repl_i};
        res_o.cnt   = ecnt + 3'd1;
      end else begin
        res_o.bytes = {8'h00, e};
        res_o.cnt   = ecnt;
      end
      res_o.pend_valid = is_hi && !unit_i.end_of_string;
    end
  end

endmodule

@@ design/json_string_escape_utf8.sv @@
`timescale 1ns / 1ps

// channel  | direction | ports                    | beat
// ---------+-----------+--------------------------+---------------------------------
// in       | input     | in_valid, in_stall       | one UTF-16 code unit + end flag
// out      | output    | out_valid, out_stall     | one escaped UTF-8 byte + flags
// cfg      | input     | cfg_we, cfg_wdata        | replacement byte
//
// A unit is held in the input register, is encoded on its way into the run
// register, and leaves there at one byte per cycle unless out_stall holds it, over
// the single output byte lane; a unit makes 1 to 7 bytes, loaded as the last leaves.
// A unit that makes no byte still goes through the input register, but
// passes on without occupying the run register.
// rst_n (synchronous) clears both registers, the held surrogate and restores '?'.
// A stall on the output holds the current byte and backs up into in_stall.
module json_string_escape_utf8 (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  jses_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output jses_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata
);

  logic [7:0]           repl_byte_r;
  logic                 a_valid_r, a_valid_nxt;
  jses_pkg::in_t        a_data_r;
  logic                 pend_valid_r;
  logic [9:0]           pend_high_r;
  logic                 b_valid_r, b_valid_nxt;
  jses_pkg::run_bytes_t b_bytes_r;
  logic [jses_pkg::CntW-1:0] b_cnt_r;
  logic [jses_pkg::CntW-1:0] b_idx_r, b_idx_nxt;
  logic                 b_eos_r;
  jses_pkg::enc_res_t   enc;
  logic                 accept, pop, b_tail, b_free, a_move, b_load;

  jses_encode u_enc (
    .unit_i       (a_data_r),
    .pend_valid_i (pend_valid_r),
    .pend_high_i  (pend_high_r),
    .repl_i       (repl_byte_r),
    .res_o        (enc)
  );

  assign pop    = b_valid_r && !out_stall;
  assign b_tail = (b_idx_r == (b_cnt_r - 3'd1));
  assign b_free = !b_valid_r || (pop && b_tail);
  assign a_move = a_valid_r && (b_free || (enc.cnt == '0));
  assign b_load = a_move && (enc.cnt != '0);
  assign in_stall = a_valid_r && !a_move;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (a_move) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    b_idx_nxt   = b_idx_r;
    if (b_load) begin
      b_valid_nxt = 1'b1;
      b_idx_nxt   = '0;
    end else if (pop) begin
      if (b_tail) begin
        b_valid_nxt = 1'b0;
      end else begin
        b_idx_nxt = b_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_byte_r  <= jses_pkg::REPL_RESET;
      a_valid_r    <= 1'b0;
      b_valid_r    <= 1'b0;
      b_idx_r      <= '0;
      pend_valid_r <= 1'b0;
      pend_high_r  <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      b_idx_r   <= b_idx_nxt;
      if (cfg_we) begin
        repl_byte_r <= cfg_wdata;
      end
      if (a_move) begin
        pend_valid_r <= enc.pend_valid;
        pend_high_r  <= enc.pend_high;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_data_r <= in_data;
    end
    if (b_load) begin
      b_bytes_r <= enc.bytes;
      b_cnt_r   <= enc.cnt;
      b_eos_r   <= a_data_r.end_of_string;
    end
  end

  assign out_valid            = b_valid_r;
  assign out_data.out_byte    = b_bytes_r[b_idx_r];
  assign out_data.last_of_run = b_tail;
  assign out_data.string_done = b_tail && b_eos_r;

endmodule

@@ test/json_string_escape_utf8_tb.sv @@
`timescale 1ns / 1ps

module json_string_escape_utf8_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HI_SURR_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_SURR_FIRST = 16'hDC00;
  localparam logic [15:0] LO_SURR_LAST  = 16'hDFFF;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  jses_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  jses_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  // escaper state as seen from outside
  logic [7:0] repl_byte = jses_pkg::REPL_RESET;
  logic [9:0] held_high = '0;
  logic       held_valid = 1'b0;
  logic [7:0] run_buf [8];
  int         run_len;

  jses_pkg::out_t esc_bytes_q [$];
  int   mismatch_cnt = 0;
  int   cycle_cnt = 0;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;

  json_string_escape_utf8 uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic is_high_surr(input logic [15:0] u);
    return u >= HI_SURR_FIRST && u <= HI_SURR_LAST;
  endfunction

  function automatic logic is_low_surr(input logic [15:0] u);
    return u >= LO_SURR_FIRST && u <= LO_SURR_LAST;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? jses_pkg::CH_ZERO + 8'(nib) : 8'h61 + 8'(nib) - 8'd10;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    if (run_len < 8) begin
      run_buf[run_len] = b;
      run_len++;
    end
  endtask

  task automatic encode_unit(input logic [15:0] u, input logic eos);
    if (u < 16'h0080) begin
      if (u < 16'(jses_pkg::CH_CTRL_LIM) || u[7:0] == jses_pkg::CH_QUOTE ||
          u[7:0] == jses_pkg::CH_BSLASH) begin
        put_byte(jses_pkg::CH_BSLASH);
        case (u[7:0])
          jses_pkg::CH_QUOTE:  put_byte(jses_pkg::CH_QUOTE);
          jses_pkg::CH_BSLASH: put_byte(jses_pkg::CH_BSLASH);
          jses_pkg::CH_BS:     put_byte(jses_pkg::CH_LO_B);
          jses_pkg::CH_FF:     put_byte(jses_pkg::CH_LO_F);
          jses_pkg::CH_NL:     put_byte(jses_pkg::CH_LO_N);
          jses_pkg::CH_CR:     put_byte(jses_pkg::CH_LO_R);
          jses_pkg::CH_TAB:    put_byte(jses_pkg::CH_LO_T);
          default: begin
            put_byte(jses_pkg::CH_LO_U);
            put_byte(jses_pkg::CH_ZERO);
            put_byte(jses_pkg::CH_ZERO);
            put_byte(hex_digit(u[7:4]));
            put_byte(hex_digit(u[3:0]));
          end
        endcase
      end else begin
        put_byte(u[7:0]);
      end
    end else if (u < 16'h0800) begin
      put_byte(jses_pkg::UTF_LEAD2 | {3'b000, u[10:6]});
      put_byte(jses_pkg::UTF_CONT | {2'b00, u[5:0]});
    end else if (is_high_surr(u)) begin
      if (eos) begin
        put_byte(repl_byte);
      end else begin
        held_high = u[9:0];
        held_valid = 1'b1;
      end
    end else if (is_low_surr(u)) begin
      put_byte(repl_byte);
    end else begin
      put_byte(jses_pkg::UTF_LEAD3 | {4'h0, u[15:12]});
      put_byte(jses_pkg::UTF_CONT | {2'b00, u[11:6]});
      put_byte(jses_pkg::UTF_CONT | {2'b00, u[5:0]});
    end
  endtask

  // work out the bytes one accepted unit causes and queue them
  task automatic escape_unit(input logic [15:0] u, input logic eos);
    logic [20:0] cp;
    jses_pkg::out_t beat;
    run_len = 0;
    if (held_valid) begin
      held_valid = 1'b0;
      if (is_low_surr(u)) begin
        cp = jses_pkg::SUPP_BASE + {1'b0, held_high, u[9:0]};
        put_byte(jses_pkg::UTF_LEAD4 | {5'b00000, cp[20:18]});
        put_byte(jses_pkg::UTF_CONT | {2'b00, cp[17:12]});
        put_byte(jses_pkg::UTF_CONT | {2'b00, cp[11:6]});
        put_byte(jses_pkg::UTF_CONT | {2'b00, cp[5:0]});
        held_high = '0;
      end else begin
        put_byte(repl_byte);
        held_high = '0;
        encode_unit(u, eos);
      end
    end else begin
      encode_unit(u, eos);
    end
    for (int k = 0; k < run_len; k++) begin
      beat.out_byte = run_buf[k];
      beat.last_of_run = (k == run_len - 1);
      beat.string_done = beat.last_of_run && eos;
      esc_bytes_q.push_back(beat);
    end
  endtask

  task automatic send_unit(input logic [15:0] u, input logic eos);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {u, eos};
    do @(posedge clk); while (in_stall);
    escape_unit(u, eos);
  endtask

  // hold off until every queued byte has left, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (esc_bytes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_replacement(input logic [7:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    repl_byte = v;
  endtask

  task automatic test_directed();
    send_unit(16'h0000, 1'b0);
    send_unit(16'h001F, 1'b0);
    send_unit(16'h0008, 1'b0);
    send_unit(16'h000C, 1'b0);
    send_unit(16'h000A, 1'b0);
    send_unit(16'h000D, 1'b0);
    send_unit(16'h0009, 1'b0);
    send_unit(16'h0022, 1'b0);
    send_unit(16'h005C, 1'b0);
    send_unit(16'h0020, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    // lowest and highest surrogate pairs, the second one closing the string
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    // high followed by an escape, then high followed by another high
    send_unit(16'hD800, 1'b0);
    send_unit(16'h000A, 1'b0);
    send_unit(16'hDABC, 1'b0);
    send_unit(16'hD801, 1'b0);
    send_unit(16'hDC01, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b1);
    send_unit(16'hD900, 1'b0);
    send_unit(16'hDA00, 1'b1);
  endtask

  task automatic test_replacement_extremes();
    logic [7:0] vals [2];
    vals[0] = 8'h00;
    vals[1] = 8'hFF;
    foreach (vals[i]) begin
      set_replacement(vals[i]);
      send_unit(16'hDC00, 1'b0);
      send_unit(16'hD800, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(16'hDBFF, 1'b1);
    end
  endtask

  task automatic build_string(ref logic [15:0] units [$]);
    int len;
    int pick;
    len = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 8);
    units.delete();
    while (units.size() < len) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        units.push_back(16'($urandom_range(16'h0020, 16'h007F)));
      end else if (pick < 35) begin
        units.push_back(16'($urandom_range(0, 16'h001F)));
      end else if (pick < 40) begin
        units.push_back($urandom_range(1) ? 16'(jses_pkg::CH_QUOTE)
                                           : 16'(jses_pkg::CH_BSLASH));
      end else if (pick < 55) begin
        units.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
      end else if (pick < 70) begin
        units.push_back($urandom_range(1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                           : 16'($urandom_range(16'hE000, 16'hFFFF)));
      end else if (pick < 88) begin
        units.push_back(16'($urandom_range(HI_SURR_FIRST, HI_SURR_LAST)));
        units.push_back(16'($urandom_range(LO_SURR_FIRST, LO_SURR_LAST)));
      end else if (pick < 93) begin
        units.push_back(16'($urandom_range(HI_SURR_FIRST, HI_SURR_LAST)));
      end else if (pick < 96) begin
        units.push_back(16'($urandom_range(LO_SURR_FIRST, LO_SURR_LAST)));
      end else begin
        units.push_back(16'($urandom_range(16'hFFFF)));
      end
    end
  endtask

  task automatic test_random_strings(input int idle_pct, input int stall_pct,
                                     input int n_units);
    logic [15:0] units [$];
    int sent;
    sent = 0;
    set_replacement(8'($urandom_range(255)));
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    while (sent < n_units) begin
      build_string(units);
      foreach (units[i]) begin
        send_unit(units[i], i == units.size() - 1);
        sent++;
      end
    end
    drain_results();
    src_idle_pct = 0;
    sink_stall_pct = 0;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk) begin : check_beat
    jses_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (esc_bytes_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected beat: byte %02h last %0b done %0b", out_data.out_byte,
                   out_data.last_of_run, out_data.string_done);
      end else begin
        want = esc_bytes_q.pop_front();
        if (out_data.out_byte !== want.out_byte ||
            out_data.last_of_run !== want.last_of_run ||
            out_data.string_done !== want.string_done) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("beat mismatch: exp byte %02h last %0b done %0b, got %02h %0b %0b",
                     want.out_byte, want.last_of_run, want.string_done,
                     out_data.out_byte, out_data.last_of_run, out_data.string_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_replacement_extremes();
    test_random_strings(0, 0, 110);
    test_random_strings(79, 0, 110);
    test_random_strings(0, 79, 110);
    test_random_strings(9, 9, 110);
    set_replacement(jses_pkg::REPL_RESET);
    send_unit(16'hDC00, 1'b1);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && esc_bytes_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ json_string_escape_utf8.f @@
design/jses_pkg.sv
design/jses_encode.sv
design/json_string_escape_utf8.sv
test/json_string_escape_utf8_tb.sv
